/* src/rals_pkg.sv */
// Shared types, codes and constants of the RGB alert LED sequencer.
package rals_pkg;

  // Item kinds carried by the mode field
  typedef enum logic {
    KIND_REFRESH   = 1'b0,
    KIND_HEARTBEAT = 1'b1
  } rals_kind_t;

  // Alert modes
  typedef enum logic [1:0] {
    ALERT_OFF       = 2'd0,
    ALERT_PROXIMITY = 2'd1,
    ALERT_WATCHLIST = 2'd2,
    ALERT_EMERGENCY = 2'd3
  } rals_alert_t;

  // Color themes; codes without a member fall back to green
  typedef enum logic [2:0] {
    THEME_GREEN  = 3'd0,
    THEME_AMBER  = 3'd1,
    THEME_BLUE   = 3'd2,
    THEME_RED    = 3'd3,
    THEME_PURPLE = 3'd4
  } rals_theme_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_THEME           = 3'd0,
    CFG_BLINK_INTERVAL  = 3'd1,
    CFG_HEARTBEAT_WIN   = 3'd2,
    CFG_AMBER_GREEN     = 3'd3,
    CFG_PURPLE_RED      = 3'd4
  } rals_cfg_index_t;

  // Number of registered stages in front of the state update
  localparam int unsigned NUM_STAGES = 5;

  // Per-stage load strobes of the front pipeline
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } rals_stage_load_t;

  // Register reset values
  localparam logic [2:0]  THEME_RESET          = 3'd0;
  localparam logic [15:0] BLINK_INTERVAL_RESET = 16'd400;
  localparam logic [15:0] HEARTBEAT_WIN_RESET  = 16'd200;
  localparam logic [7:0]  AMBER_GREEN_RESET    = 8'd25;
  localparam logic [7:0]  PURPLE_RED_RESET     = 8'd130;

  // State reset values
  localparam logic [31:0] HEARTBEAT_START_RESET = 32'd4294967095;

  // Update triple-blink timing in ms
  localparam logic [13:0] UPD_BURST_MS = 14'd720;
  localparam logic [13:0] UPD_SLOT_MS  = 14'd240;
  localparam logic [13:0] UPD_ON_MS    = 14'd120;

  // Reciprocals for exact constant division over the ranges used
  // (now >> 4) / 625 for 28-bit operands: (x * RECIP_625) >> 38
  localparam logic [28:0] RECIP_625 = 29'd439804652;
  localparam int unsigned SHIFT_625 = 38;
  localparam logic [9:0]  DIV_625   = 10'd625;
  // (now >> 3) / 25 for 29-bit operands: (x * RECIP_25) >> 34
  localparam logic [29:0] RECIP_25  = 30'd687194768;
  localparam int unsigned SHIFT_25  = 34;
  // x / 17 for 24-bit operands: (x * RECIP_17) >> 29
  localparam logic [24:0] RECIP_17  = 25'd31580642;
  localparam int unsigned SHIFT_17  = 29;
  localparam logic [4:0]  DIV_17    = 5'd17;

  // SOS pattern over 34 units of 200 ms, one bit per unit (1 = lit)
  localparam int unsigned SOS_UNITS = 34;
  localparam logic [SOS_UNITS-1:0] SOS_MASK = 34'h0_0547_7715;

endpackage

/* src/rgb_alert_led_sequencer_top.sv */
// Top level of the RGB alert LED sequencer: pipeline control, state and results.
// Latency: a refresh result is registered once its item leaves the last front stage; a
// heartbeat item takes effect at the same point and gives no result.
// Throughput: one item per cycle while out_ready does not stall the result; the depth is set by the three
// reciprocal multiplications that reduce the time stamp to its blink phases.
// Reset: synchronous rst clears the pipeline and result valid, and restores
// the configuration registers and state to their reset values.
module rgb_alert_led_sequencer_top
  import rals_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [1:0]  alert_mode,
  input  logic [31:0] now_ms,
  input  logic        update_available,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_duty,
  output logic [7:0]  green_duty,
  output logic [7:0]  blue_duty,
  output logic        blink_on
);

  typedef struct packed {
    logic        kind;
    logic [1:0]  alert;
    logic [31:0] now;
    logic        upd;
  } item_t;

  // Configuration registers
  logic [2:0]  theme;
  logic [15:0] blink_interval_ms;
  logic [15:0] heartbeat_window_ms;
  logic [7:0]  amber_green_level;
  logic [7:0]  purple_red_level;

  // Sequencer state
  logic        blink_phase;
  logic [31:0] last_toggle_time;
  logic [1:0]  previous_alert_mode;
  logic [31:0] heartbeat_start;

  logic        blink_phase_next;
  logic [31:0] last_toggle_time_next;
  logic [1:0]  previous_alert_mode_next;

  // Front pipeline
  item_t                 stage [NUM_STAGES];
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   accept;
  rals_stage_load_t      stage_ld;
  item_t                 cur;
  logic                  upd_lit;
  logic                  sos_lit;

  // Execution step
  logic        out_free;
  logic        fire;
  logic        fire_refresh;
  logic        hb_open;
  logic        upd_on;
  logic        mode_changed;
  logic        phase_base;
  logic [31:0] toggle_base;
  logic [2:0]  theme_rgb;
  logic [2:0]  mode_rgb;
  logic [23:0] duty_next;
  logic        blink_next;

  // Theme color as {red, green, blue} on/off
  function automatic logic [2:0] theme_colors(input logic [2:0] t);
    logic [2:0] c;
    unique case (t)
      THEME_AMBER:  c = 3'b110;
      THEME_BLUE:   c = 3'b001;
      THEME_RED:    c = 3'b100;
      THEME_PURPLE: c = 3'b101;
      default:      c = 3'b010;
    endcase
    return c;
  endfunction

  // Inverted duties {red, green, blue} for an on/off color with mixes
  function automatic logic [23:0] mix_duty(input logic [2:0] c, input logic [7:0] amber,
                                           input logic [7:0] purple);
    logic [23:0] lvl;
    if (c == 3'b110) begin
      lvl = {8'hFF, amber, 8'h00};
    end else if (c == 3'b101) begin
      lvl = {purple, 8'h00, 8'hFF};
    end else begin
      lvl = {{8{c[2]}}, {8{c[1]}}, {8{c[0]}}};
    end
    return ~lvl;
  endfunction

  rals_phase u_phase (
    .clk     (clk),
    .ld      (stage_ld),
    .now_ms  (now_ms),
    .upd_lit (upd_lit),
    .sos_lit (sos_lit)
  );

  // Stage acceptance: a stage loads when empty or when its item moves on
  assign out_free = !out_valid || out_ready;
  always_comb begin
    accept[NUM_STAGES] = out_free;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      accept[k] = !valid[k] || accept[k+1];
    end
  end
  assign stage_ld.load = accept[NUM_STAGES-1:0];
  assign in_ready      = accept[0];

  assign cur          = stage[NUM_STAGES-1];
  assign fire         = valid[NUM_STAGES-1] && out_free;
  assign fire_refresh = fire && (cur.kind == KIND_REFRESH);

  // Compute the next state and the result for the item at the pipeline end
  always_comb begin
    hb_open      = (cur.now - heartbeat_start) < {16'd0, heartbeat_window_ms};
    upd_on       = cur.upd && (cur.alert != ALERT_EMERGENCY) && upd_lit;
    theme_rgb    = theme_colors(theme);
    mode_changed = cur.alert != previous_alert_mode;
    phase_base   = mode_changed ? 1'b1 : blink_phase;
    toggle_base  = mode_changed ? cur.now : last_toggle_time;
    mode_rgb     = theme_rgb;
    blink_phase_next         = phase_base;
    last_toggle_time_next    = toggle_base;
    previous_alert_mode_next = cur.alert;
    duty_next                = 24'hFFFFFF;
    blink_next               = 1'b0;
    unique case (cur.alert)
      ALERT_OFF: begin
        blink_phase_next      = 1'b0;
        last_toggle_time_next = last_toggle_time;
        if (hb_open) begin
          duty_next  = mix_duty(theme_rgb, amber_green_level, purple_red_level);
          blink_next = 1'b1;
        end else if (upd_on) begin
          duty_next  = 24'h000000;
          blink_next = 1'b1;
        end
      end
      ALERT_EMERGENCY: begin
        blink_phase_next = sos_lit;
        duty_next  = mix_duty({sos_lit, 2'b00}, amber_green_level, purple_red_level);
        blink_next = sos_lit;
      end
      default: begin
        if (cur.alert == ALERT_WATCHLIST) begin
          mode_rgb = 3'b011;
        end
        if ((cur.now - toggle_base) >= {16'd0, blink_interval_ms}) begin
          last_toggle_time_next = cur.now;
          blink_phase_next      = !phase_base;
        end
        if (hb_open || upd_on) begin
          duty_next = 24'h000000;
        end else begin
          duty_next = mix_duty(mode_rgb & {3{blink_phase_next}}, amber_green_level,
                               purple_red_level);
        end
        blink_next = blink_phase_next;
      end
    endcase
  end

  // Hold configuration, advance the pipeline, update state and results
  always_ff @(posedge clk) begin
    if (rst) begin
      theme               <= THEME_RESET;
      blink_interval_ms   <= BLINK_INTERVAL_RESET;
      heartbeat_window_ms <= HEARTBEAT_WIN_RESET;
      amber_green_level   <= AMBER_GREEN_RESET;
      purple_red_level    <= PURPLE_RED_RESET;
      blink_phase         <= 1'b0;
      last_toggle_time    <= 32'd0;
      previous_alert_mode <= ALERT_OFF;
      heartbeat_start     <= HEARTBEAT_START_RESET;
      valid               <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THEME:          theme               <= cfg_data[2:0];
          CFG_BLINK_INTERVAL: blink_interval_ms   <= cfg_data;
          CFG_HEARTBEAT_WIN:  heartbeat_window_ms <= cfg_data;
          CFG_AMBER_GREEN:    amber_green_level   <= cfg_data[7:0];
          CFG_PURPLE_RED:     purple_red_level    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (accept[k]) begin
          valid[k] <= valid[k-1];
        end
      end
      if (fire && (cur.kind == KIND_HEARTBEAT)) begin
        heartbeat_start <= cur.now;
      end
      if (fire_refresh) begin
        blink_phase         <= blink_phase_next;
        last_toggle_time    <= last_toggle_time_next;
        previous_alert_mode <= previous_alert_mode_next;
        out_valid           <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pipeline and result payload
  always_ff @(posedge clk) begin
    if (accept[0]) begin
      stage[0] <= '{kind: mode, alert: alert_mode, now: now_ms, upd: update_available};
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (accept[k]) begin
        stage[k] <= stage[k-1];
      end
    end
    if (fire_refresh) begin
      red_duty   <= duty_next[23:16];
      green_duty <= duty_next[15:8];
      blue_duty  <= duty_next[7:0];
      blink_on   <= blink_next;
    end
  end

  // A new result only ever follows an executed refresh item
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire_refresh))
    else $error("result appeared without a refresh item");

  // Off mode clears the blink phase and the remembered mode
  a_off_clears: assert property (@(posedge clk) disable iff (rst)
    (fire_refresh && (cur.alert == ALERT_OFF)) |=>
      (!blink_phase && (previous_alert_mode == ALERT_OFF)))
    else $error("off mode left blink state behind");

  // Emergency shows pure red following the blink flag
  a_emergency_red: assert property (@(posedge clk) disable iff (rst)
    (fire_refresh && (cur.alert == ALERT_EMERGENCY)) |=>
      ((red_duty == (blink_on ? 8'h00 : 8'hFF)) && (green_duty == 8'hFF) &&
       (blue_duty == 8'hFF) && (blink_on == blink_phase)))
    else $error("emergency result is not plain red");

endmodule

/* src/rals_phase.sv */
// Time-phase pipeline: update-blink and SOS phase of each item's time stamp.
module rals_phase
  import rals_pkg::*;
(
  input  logic             clk,
  input  rals_stage_load_t ld,
  input  logic [31:0]      now_ms,
  output logic             upd_lit,
  output logic             sos_lit
);

  // Stage 1: captured time stamp
  logic [31:0] now1;

  // Stage 2: quotients from the reciprocal products
  logic [18:0] q625_2;
  logic [27:0] h2;
  logic [3:0]  l2;
  logic [24:0] q25_2;

  // Stage 3: phase within the 10 s update cycle, 200 ms unit count split
  logic [13:0] pu3;
  logic [23:0] x3;
  logic        b3;

  // Stage 4: update flag and quotient by 17
  logic        upd4;
  logic [19:0] q17_4;
  logic [23:0] x4;
  logic        b4;

  // Stage 5: final flags
  logic        upd5;
  logic        sos5;

  // Combinational terms between the stages
  logic [56:0] prod625;
  logic [58:0] prod25;
  logic [27:0] qm625;
  logic [27:0] r625;
  logic [48:0] prod17;
  logic [23:0] qm17;
  logic [23:0] r17;
  logic [5:0]  sos_unit;

  // Lit slots of the triple blink: first 720 ms, 120 ms out of every 240 ms
  function automatic logic update_phase_lit(input logic [13:0] p);
    logic [13:0] m;
    if (p < UPD_SLOT_MS) begin
      m = p;
    end else if (p < 14'(2 * UPD_SLOT_MS)) begin
      m = p - UPD_SLOT_MS;
    end else begin
      m = p - 14'(2 * UPD_SLOT_MS);
    end
    return (p < UPD_BURST_MS) && (m < UPD_ON_MS);
  endfunction

  // Look up the SOS pattern for one 200 ms unit
  function automatic logic sos_unit_lit(input logic [5:0] u);
    logic lit;
    lit = 1'b0;
    if (u < 6'(SOS_UNITS)) begin
      lit = SOS_MASK[u];
    end
    return lit;
  endfunction

  assign prod625  = 57'(now1[31:4]) * 57'(RECIP_625);
  assign prod25   = 59'(now1[31:3]) * 59'(RECIP_25);
  assign qm625    = 28'(q625_2) * 28'(DIV_625);
  assign r625     = h2 - qm625;
  assign prod17   = 49'(x3) * 49'(RECIP_17);
  assign qm17     = 24'(q17_4) * 24'(DIV_17);
  assign r17      = x4 - qm17;
  assign sos_unit = {r17[4:0], b4};

  // Advance each stage on its load strobe
  always_ff @(posedge clk) begin
    if (ld.load[0]) begin
      now1 <= now_ms;
    end
    if (ld.load[1]) begin
      q625_2 <= prod625[56:SHIFT_625];
      h2     <= now1[31:4];
      l2     <= now1[3:0];
      q25_2  <= prod25[58:SHIFT_25];
    end
    if (ld.load[2]) begin
      pu3 <= {r625[9:0], l2};
      x3  <= q25_2[24:1];
      b3  <= q25_2[0];
    end
    if (ld.load[3]) begin
      upd4  <= update_phase_lit(pu3);
      q17_4 <= prod17[48:SHIFT_17];
      x4    <= x3;
      b4    <= b3;
    end
    if (ld.load[4]) begin
      upd5 <= upd4;
      sos5 <= sos_unit_lit(sos_unit);
    end
  end

  assign upd_lit = upd5;
  assign sos_lit = sos5;

endmodule
